// ----- design/rlb_pkg.sv -----
// Shared types and constants for the RGB layer blender.
// Used by every module of the rgb_layer_blend block.
package rlb_pkg;

	localparam int ALPHA_SCALE = 10;

	localparam int CHAN_W = 8;
	localparam int ALPHA_W = 4;
	localparam int MODE_W = 3;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W = 4;
	localparam int NUM_CHAN = 3;

	localparam int SUM_W = 17;
	localparam int QUO_W = 9;
	localparam int RECIP_SHIFT = SUM_W;
	localparam int RECIP_W = RECIP_SHIFT + 1;
	localparam int PROD_W = SUM_W + RECIP_W;

	localparam logic [CHAN_W-1:0] SCALE_B = CHAN_W'(ALPHA_SCALE);
	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;
	localparam logic [CHAN_W-1:0] OVERLAY_SPLIT = 8'd128;
	localparam logic [QUO_W-1:0] DIV_SCALE = QUO_W'(ALPHA_SCALE);
	localparam logic [QUO_W-1:0] DIV_255 = 9'd255;
	localparam logic [RECIP_W-1:0] RECIP_SCALE = RECIP_W'((2 ** RECIP_SHIFT) / ALPHA_SCALE);
	localparam logic [RECIP_W-1:0] RECIP_255 = RECIP_W'((2 ** RECIP_SHIFT) / 255);

	localparam logic [MODE_W-1:0] MODE_PASS = 3'd0;
	localparam logic [MODE_W-1:0] MODE_NORMAL = 3'd1;
	localparam logic [MODE_W-1:0] MODE_MULTIPLY = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SCREEN = 3'd3;
	localparam logic [MODE_W-1:0] MODE_OVERLAY = 3'd4;

	localparam logic [CFG_INDEX_W-1:0] REG_BLEND_MODE = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_STEPS = 1'd1;

	typedef struct packed {
		logic [CHAN_W-1:0] base_red;
		logic [CHAN_W-1:0] base_green;
		logic [CHAN_W-1:0] base_blue;
		logic [CHAN_W-1:0] over_red;
		logic [CHAN_W-1:0] over_green;
		logic [CHAN_W-1:0] over_blue;
	} layers_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_red;
		logic [CHAN_W-1:0] out_green;
		logic [CHAN_W-1:0] out_blue;
	} pixel_t;

	typedef struct packed {
		logic [CHAN_W-1:0] x;
		logic [CHAN_W-1:0] y;
		logic [CHAN_W-1:0] v;
		logic [CHAN_W-1:0] base;
		logic dbl;
		logic invert;
	} op_chan_t;

	typedef struct packed {
		op_chan_t [NUM_CHAN-1:0] ch;
		logic [ALPHA_W-1:0] a;
		logic norm;
		logic pass;
	} op_beat_t;

	typedef struct packed {
		logic [SUM_W-1:0] n;
		logic [CHAN_W-1:0] base;
		logic invert;
	} sum_chan_t;

	typedef struct packed {
		sum_chan_t [NUM_CHAN-1:0] ch;
		logic norm;
		logic pass;
	} sum_beat_t;

	typedef struct packed {
		logic [SUM_W-1:0] n;
		logic [QUO_W-1:0] q_est;
		logic [CHAN_W-1:0] base;
		logic invert;
	} quo_chan_t;

	typedef struct packed {
		quo_chan_t [NUM_CHAN-1:0] ch;
		logic norm;
		logic pass;
	} quo_beat_t;

endpackage

// ----- design/rlb_in_if.sv -----
// Input stream interface: one base pixel and one overlay pixel per beat.
// Depends on rlb_pkg for the channel width.
interface rlb_in_if;
	logic valid;
	logic ready;
	logic [rlb_pkg::CHAN_W-1:0] base_red;
	logic [rlb_pkg::CHAN_W-1:0] base_green;
	logic [rlb_pkg::CHAN_W-1:0] base_blue;
	logic [rlb_pkg::CHAN_W-1:0] over_red;
	logic [rlb_pkg::CHAN_W-1:0] over_green;
	logic [rlb_pkg::CHAN_W-1:0] over_blue;

	modport source (output valid, base_red, base_green, base_blue,
		over_red, over_green, over_blue, input ready);
	modport sink (input valid, base_red, base_green, base_blue,
		over_red, over_green, over_blue, output ready);
endinterface

// ----- design/rlb_out_if.sv -----
// Output stream interface: one blended pixel per beat.
// Depends on rlb_pkg for the channel width.
interface rlb_out_if;
	logic valid;
	logic ready;
	logic [rlb_pkg::CHAN_W-1:0] out_red;
	logic [rlb_pkg::CHAN_W-1:0] out_green;
	logic [rlb_pkg::CHAN_W-1:0] out_blue;

	modport source (output valid, out_red, out_green, out_blue, input ready);
	modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

// ----- design/rlb_operand.sv -----
// Stage 1: decode the blend mode and pick multiplier operands per channel.
// Depends on rlb_pkg.
module rlb_operand (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  rlb_pkg::layers_t             layers,
	input  logic [rlb_pkg::MODE_W-1:0]   mode,
	input  logic [rlb_pkg::ALPHA_W-1:0]  alpha,
	output logic                         out_valid,
	input  logic                         out_ready,
	output rlb_pkg::op_beat_t            beat
);

	logic v_s1;
	rlb_pkg::op_beat_t beat_s1;
	rlb_pkg::op_beat_t next;
	logic [rlb_pkg::CHAN_W-1:0] b [rlb_pkg::NUM_CHAN];
	logic [rlb_pkg::CHAN_W-1:0] o [rlb_pkg::NUM_CHAN];
	logic [rlb_pkg::ALPHA_W-1:0] a_cl;
	logic [rlb_pkg::CHAN_W-1:0] inv_a;

	assign b[2] = layers.base_red;
	assign b[1] = layers.base_green;
	assign b[0] = layers.base_blue;
	assign o[2] = layers.over_red;
	assign o[1] = layers.over_green;
	assign o[0] = layers.over_blue;

	// clamp opacity to full scale
	assign a_cl = ({4'b0, alpha} > rlb_pkg::SCALE_B) ?
		rlb_pkg::SCALE_B[rlb_pkg::ALPHA_W-1:0] : alpha;
	assign inv_a = rlb_pkg::SCALE_B - {4'b0, a_cl};

	always_comb begin
		next = '0;
		next.pass = 1'b0;
		next.norm = 1'b0;
		next.a = '0;
		unique case (mode)
			rlb_pkg::MODE_NORMAL: begin
				next.norm = 1'b1;
				next.a = a_cl;
			end
			rlb_pkg::MODE_MULTIPLY, rlb_pkg::MODE_SCREEN, rlb_pkg::MODE_OVERLAY: begin
				next.pass = 1'b0;
			end
			default: begin
				next.pass = 1'b1;
			end
		endcase
		for (int c = 0; c < rlb_pkg::NUM_CHAN; c++) begin
			next.ch[c].base = b[c];
			next.ch[c].v = o[c];
			next.ch[c].x = b[c];
			next.ch[c].y = o[c];
			next.ch[c].dbl = 1'b0;
			next.ch[c].invert = 1'b0;
			unique case (mode)
				rlb_pkg::MODE_NORMAL: begin
					next.ch[c].x = inv_a;
					next.ch[c].y = b[c];
				end
				rlb_pkg::MODE_SCREEN: begin
					next.ch[c].x = rlb_pkg::CHAN_MAX - b[c];
					next.ch[c].y = rlb_pkg::CHAN_MAX - o[c];
					next.ch[c].invert = 1'b1;
				end
				rlb_pkg::MODE_OVERLAY: begin
					next.ch[c].dbl = 1'b1;
					if (b[c] >= rlb_pkg::OVERLAY_SPLIT) begin
						next.ch[c].x = rlb_pkg::CHAN_MAX - b[c];
						next.ch[c].y = rlb_pkg::CHAN_MAX - o[c];
						next.ch[c].invert = 1'b1;
					end
				end
				default: begin
					next.ch[c].dbl = 1'b0;
				end
			endcase
		end
	end

	assign in_ready = !v_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			beat_s1 <= next;
		end
	end

	assign out_valid = v_s1;
	assign beat = beat_s1;

endmodule

// ----- design/rlb_product.sv -----
// Stage 2: form the blend numerator per channel from two small products.
// Depends on rlb_pkg.
module rlb_product (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  rlb_pkg::op_beat_t     in_beat,
	output logic                  out_valid,
	input  logic                  out_ready,
	output rlb_pkg::sum_beat_t    beat
);

	logic v_s2;
	rlb_pkg::sum_beat_t beat_s2;
	rlb_pkg::sum_beat_t next;
	logic [15:0] p1 [rlb_pkg::NUM_CHAN];
	logic [11:0] p2 [rlb_pkg::NUM_CHAN];

	always_comb begin
		next.norm = in_beat.norm;
		next.pass = in_beat.pass;
		for (int c = 0; c < rlb_pkg::NUM_CHAN; c++) begin
			p1[c] = {8'b0, in_beat.ch[c].x} * {8'b0, in_beat.ch[c].y};
			p2[c] = {8'b0, in_beat.a} * {4'b0, in_beat.ch[c].v};
			next.ch[c].n = (in_beat.ch[c].dbl ? {p1[c], 1'b0} : {1'b0, p1[c]})
				+ {5'b0, p2[c]};
			next.ch[c].base = in_beat.ch[c].base;
			next.ch[c].invert = in_beat.ch[c].invert;
		end
	end

	assign in_ready = !v_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (in_ready) begin
			v_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			beat_s2 <= next;
		end
	end

	assign out_valid = v_s2;
	assign beat = beat_s2;

endmodule

// ----- design/rlb_divide.sv -----
// Stages 3 and 4: divide by 255 or by the alpha scale through a reciprocal,
// correct by one, and finish the result. Depends on rlb_pkg.
module rlb_divide (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  rlb_pkg::sum_beat_t    in_beat,
	output logic                  out_valid,
	input  logic                  out_ready,
	output rlb_pkg::pixel_t       pixel
);

	logic v_s3;
	logic v_s4;
	logic ready_s4;
	rlb_pkg::quo_beat_t beat_s3;
	rlb_pkg::quo_beat_t next3;
	rlb_pkg::pixel_t pix_s4;
	rlb_pkg::pixel_t next4;
	logic [rlb_pkg::RECIP_W-1:0] recip;
	logic [rlb_pkg::PROD_W-1:0] prod [rlb_pkg::NUM_CHAN];
	logic [rlb_pkg::QUO_W-1:0] div;
	logic [rlb_pkg::SUM_W-1:0] qd [rlb_pkg::NUM_CHAN];
	logic [rlb_pkg::SUM_W-1:0] rem [rlb_pkg::NUM_CHAN];
	logic [rlb_pkg::QUO_W-1:0] q_fix [rlb_pkg::NUM_CHAN];
	logic [rlb_pkg::CHAN_W-1:0] res [rlb_pkg::NUM_CHAN];

	assign recip = in_beat.norm ? rlb_pkg::RECIP_SCALE : rlb_pkg::RECIP_255;

	always_comb begin
		next3.norm = in_beat.norm;
		next3.pass = in_beat.pass;
		for (int c = 0; c < rlb_pkg::NUM_CHAN; c++) begin
			prod[c] = rlb_pkg::PROD_W'(in_beat.ch[c].n) * rlb_pkg::PROD_W'(recip);
			next3.ch[c].n = in_beat.ch[c].n;
			next3.ch[c].q_est = prod[c][rlb_pkg::RECIP_SHIFT +: rlb_pkg::QUO_W];
			next3.ch[c].base = in_beat.ch[c].base;
			next3.ch[c].invert = in_beat.ch[c].invert;
		end
	end

	assign div = beat_s3.norm ? rlb_pkg::DIV_SCALE : rlb_pkg::DIV_255;

	// the estimate is low by at most one: fix with one compare
	always_comb begin
		for (int c = 0; c < rlb_pkg::NUM_CHAN; c++) begin
			qd[c] = rlb_pkg::SUM_W'({8'b0, beat_s3.ch[c].q_est} * {8'b0, div});
			rem[c] = beat_s3.ch[c].n - qd[c];
			q_fix[c] = beat_s3.ch[c].q_est
				+ rlb_pkg::QUO_W'(rem[c] >= rlb_pkg::SUM_W'(div));
			if (beat_s3.pass) begin
				res[c] = beat_s3.ch[c].base;
			end else if (beat_s3.ch[c].invert) begin
				res[c] = rlb_pkg::CHAN_MAX - q_fix[c][rlb_pkg::CHAN_W-1:0];
			end else begin
				res[c] = q_fix[c][rlb_pkg::CHAN_W-1:0];
			end
		end
		next4.out_red = res[2];
		next4.out_green = res[1];
		next4.out_blue = res[0];
	end

	assign ready_s4 = !v_s4 || out_ready;
	assign in_ready = !v_s3 || ready_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s3 <= in_valid;
			end
			if (ready_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			beat_s3 <= next3;
		end
		if (ready_s4 && v_s3) begin
			pix_s4 <= next4;
		end
	end

	assign out_valid = v_s4;
	assign pixel = pix_s4;

`ifndef SYNTHESIS
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (rem[0] < {7'b0, div, 1'b0}) && (rem[1] < {7'b0, div, 1'b0})
			&& (rem[2] < {7'b0, div, 1'b0}))
		else $error("quotient estimate off by more than one");
	a_quo_fits: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !beat_s3.pass |-> (q_fix[0] <= 9'd255) && (q_fix[1] <= 9'd255)
			&& (q_fix[2] <= 9'd255))
		else $error("blend quotient exceeds channel range");
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !ready_s4 |=> v_s3 && $stable(beat_s3))
		else $error("stage 3 beat lost while stage 4 stalled");
`endif

endmodule

// ----- design/rgb_layer_blend.sv -----
// RGB layer blender top level: configuration registers and the four-stage
// blend pipeline. Depends on rlb_pkg, rlb_in_if, rlb_out_if, rlb_operand,
// rlb_product and rlb_divide.
//
// Usage: the layers channel carries one base pixel and one overlay pixel
// per beat; the blended channel returns one RGB888 pixel per beat, in order.
// blend_mode (index 0) picks pass-through, normal, multiply, screen or
// overlay; alpha_steps (index 1) sets the normal-mode opacity in steps of
// 1/ALPHA_SCALE. Write them through write_en/reg_index/write_data while the
// pipeline is empty; each beat takes the settings at its acceptance.
// Path: an accepted beat passes through the operand, product, reciprocal
// multiply and correct/output stages, one register each, and is valid on
// the output from the correct/output stage register.
// Throughput: one pixel per clock while the receiver holds ready high;
// every stage takes a new beat each cycle its successor moves on, and the
// multiplies are split over the product, reciprocal and correction stages.
// Reset: all stage valid bits clear, blend_mode returns to pass-through and
// alpha_steps to zero.
// Stall: when the receiver holds ready low, each stage keeps its beat; the
// pipeline keeps accepting until the bubbles are filled, then ready drops.
module rgb_layer_blend (
	input  logic                             clk,
	input  logic                             arst_n,
	rlb_in_if.sink                           layers,
	rlb_out_if.source                        blended,
	input  logic                             write_en,
	input  logic [rlb_pkg::CFG_INDEX_W-1:0]  reg_index,
	input  logic [rlb_pkg::CFG_DATA_W-1:0]   write_data
);

	logic [rlb_pkg::MODE_W-1:0] blend_mode_q;
	logic [rlb_pkg::ALPHA_W-1:0] alpha_steps_q;
	rlb_pkg::layers_t in_pix;
	rlb_pkg::op_beat_t op_beat;
	rlb_pkg::sum_beat_t sum_beat;
	rlb_pkg::pixel_t out_pix;
	logic op_valid;
	logic op_ready;
	logic sum_valid;
	logic sum_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_mode_q <= rlb_pkg::MODE_PASS;
			alpha_steps_q <= '0;
		end else if (write_en) begin
			unique case (reg_index)
				rlb_pkg::REG_BLEND_MODE: begin
					blend_mode_q <= write_data[rlb_pkg::MODE_W-1:0];
				end
				rlb_pkg::REG_ALPHA_STEPS: begin
					alpha_steps_q <= write_data[rlb_pkg::ALPHA_W-1:0];
				end
				default: begin
					alpha_steps_q <= alpha_steps_q;
				end
			endcase
		end
	end

	assign in_pix.base_red = layers.base_red;
	assign in_pix.base_green = layers.base_green;
	assign in_pix.base_blue = layers.base_blue;
	assign in_pix.over_red = layers.over_red;
	assign in_pix.over_green = layers.over_green;
	assign in_pix.over_blue = layers.over_blue;

	rlb_operand u_operand (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (layers.valid),
		.in_ready  (layers.ready),
		.layers    (in_pix),
		.mode      (blend_mode_q),
		.alpha     (alpha_steps_q),
		.out_valid (op_valid),
		.out_ready (op_ready),
		.beat      (op_beat)
	);

	rlb_product u_product (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (op_valid),
		.in_ready  (op_ready),
		.in_beat   (op_beat),
		.out_valid (sum_valid),
		.out_ready (sum_ready),
		.beat      (sum_beat)
	);

	rlb_divide u_divide (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sum_valid),
		.in_ready  (sum_ready),
		.in_beat   (sum_beat),
		.out_valid (blended.valid),
		.out_ready (blended.ready),
		.pixel     (out_pix)
	);

	assign blended.out_red = out_pix.out_red;
	assign blended.out_green = out_pix.out_green;
	assign blended.out_blue = out_pix.out_blue;

endmodule
